FILE: hw/rtl/plr_pkg.sv
// Shared constants and controller/datapath handshake types for the palindromic-length block.
package plr_pkg;

   localparam int unsigned MAX_LEN_DEFAULT = 1024;
   localparam int unsigned CHAR_W          = 8;
   localparam int unsigned OUT_W           = 11;

   typedef struct packed {
      logic load;       // take the request payload, apply a string start
      logic init_walk;  // set up the suffix walk for the new character
      logic issue;      // read the stores for the current suffix length
      logic commit;     // store the answer and fill the result register
      logic emit_ovf;   // fill the result register with an overflow answer
   } plr_cmd_type;

   typedef struct packed {
      logic full;        // capacity already used up
      logic last_issue;  // current suffix length is one
      logic out_free;    // result register can take a new answer
   } plr_status_type;

endpackage

FILE: hw/rtl/plr_channels.sv
// Valid/ready channel interfaces for characters in and prefix answers out.
interface plr_req_if;
   logic                        valid;
   logic                        ready;
   logic [plr_pkg::CHAR_W-1:0]  ch;
   logic                        starts_string;

   modport source (output valid, output ch, output starts_string, input ready);
   modport sink   (input valid, input ch, input starts_string, output ready);
endinterface

interface plr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [plr_pkg::OUT_W-1:0]   prefix_length;
   logic [plr_pkg::OUT_W-1:0]   min_parts;
   logic                        overflow;

   modport source (output valid, output prefix_length, output min_parts, output overflow,
                   input ready);
   modport sink   (input valid, input prefix_length, input min_parts, input overflow,
                   output ready);
endinterface

FILE: hw/rtl/plr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/plr_ctrl.sv
// Controller state machine: sequences load, suffix walk, commit and overflow answers.
module plr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output plr_pkg::plr_cmd_type    cmd,
   input  plr_pkg::plr_status_type status
);
   import plr_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_WALK   = 3'd2;
   localparam logic [2:0] ST_DRAIN  = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;
   localparam logic [2:0] ST_OVF    = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.full) begin
               state_in = ST_OVF;
            end else begin
               cmd.init_walk = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // let the last suffix length clear the compare stage
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_OVF: begin
            if (status.out_free) begin
               cmd.emit_ovf = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hw/rtl/plr_dp.sv
// Datapath: character, answer and suffix-map stores, suffix compare stage, result register.
module plr_dp #(
   parameter int unsigned MAX_LEN = plr_pkg::MAX_LEN_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [plr_pkg::CHAR_W-1:0]  req_ch,
   input  logic                        req_starts_string,
   input  plr_pkg::plr_cmd_type        cmd,
   output plr_pkg::plr_status_type     status,
   plr_rsp_if.source                   rsp_chan
);
   import plr_pkg::*;

   localparam int unsigned PW = $clog2(MAX_LEN + 1);
   localparam int unsigned AW = $clog2(MAX_LEN);
   localparam int unsigned EW = (PW > OUT_W) ? PW : OUT_W;

   logic [PW-1:0]     n_ff;
   logic [CHAR_W-1:0] c_ff;
   logic [PW-1:0]     len_ff;
   logic [PW-1:0]     best_ff;
   logic [PW-1:0]     last_parts_ff;
   logic              s1_vld_ff;
   logic [PW-1:0]     s1_len_ff;

   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_len_ff;
   logic [OUT_W-1:0]  rsp_parts_ff;
   logic              rsp_ovf_ff;

   logic [PW-1:0]     m;
   logic [PW-1:0]     char_off;
   logic [PW-1:0]     parts_off;
   logic [PW-1:0]     best_plus;
   logic [EW-1:0]     m_ext;
   logic [EW-1:0]     best_ext;
   logic [EW-1:0]     last_ext;
   logic [EW-1:0]     max_ext;

   logic [CHAR_W-1:0] char_rd;
   logic [PW-1:0]     parts_rd;
   logic              map_rd;
   logic              pal;
   logic [PW-1:0]     cand;

   assign m         = n_ff + PW'(1);
   assign char_off  = m - len_ff;
   assign parts_off = n_ff - len_ff;
   assign best_plus = best_ff + PW'(1);
   assign m_ext     = EW'(m);
   assign best_ext  = EW'(best_plus);
   assign last_ext  = EW'(last_parts_ff);
   assign max_ext   = EW'(MAX_LEN);

   plr_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_char_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (n_ff[AW-1:0]),
      .wr_data (c_ff),
      .rd_addr (char_off[AW-1:0]),
      .rd_data (char_rd)
   );

   plr_ram #(.WIDTH(PW), .DEPTH(MAX_LEN)) u_parts_ram (
      .clock   (clock),
      .wr_en   (cmd.commit),
      .wr_addr (n_ff[AW-1:0]),
      .wr_data (best_plus),
      .rd_addr (parts_off[AW-1:0]),
      .rd_data (parts_rd)
   );

   // bit L of the map: suffix of length L is a palindrome; bits 1..n are always fresh
   plr_ram #(.WIDTH(1), .DEPTH(MAX_LEN + 1)) u_map_ram (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_len_ff),
      .wr_data (pal),
      .rd_addr (len_ff - PW'(2)),
      .rd_data (map_rd)
   );

   // compare stage: store data for s1_len_ff has arrived
   always_comb begin
      pal  = (s1_len_ff == PW'(1)) ||
             ((char_rd == c_ff) && ((s1_len_ff == PW'(2)) || map_rd));
      cand = (s1_len_ff == m) ? '0 : parts_rd;
   end

   assign status.full       = (n_ff == PW'(MAX_LEN));
   assign status.last_issue = (len_ff == PW'(1));
   assign status.out_free   = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff         <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
         if (cmd.load && req_starts_string) begin
            n_ff <= '0;
         end else if (cmd.commit) begin
            n_ff <= m;
         end
         if (cmd.commit || cmd.emit_ovf) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         c_ff <= req_ch;
      end
      if (cmd.init_walk) begin
         len_ff  <= m;
         best_ff <= '1;
      end else begin
         if (cmd.issue) begin
            len_ff <= len_ff - PW'(1);
         end
         if (s1_vld_ff && pal && (cand < best_ff)) begin
            best_ff <= cand;
         end
      end
      s1_len_ff <= len_ff;
      if (cmd.commit) begin
         last_parts_ff <= best_plus;
         rsp_len_ff    <= m_ext[OUT_W-1:0];
         rsp_parts_ff  <= best_ext[OUT_W-1:0];
         rsp_ovf_ff    <= 1'b0;
      end else if (cmd.emit_ovf) begin
         rsp_len_ff    <= max_ext[OUT_W-1:0];
         rsp_parts_ff  <= last_ext[OUT_W-1:0];
         rsp_ovf_ff    <= 1'b1;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.prefix_length = rsp_len_ff;
   assign rsp_chan.min_parts     = rsp_parts_ff;
   assign rsp_chan.overflow      = rsp_ovf_ff;

endmodule

FILE: hw/rtl/palindromic_length_of_prefixes.sv
// Top level: palindromic length of every prefix of a streamed byte string.
//
//   channel   direction  payload
//   req_chan  in         ch[7:0], starts_string
//   rsp_chan  out        prefix_length[10:0], min_parts[10:0], overflow
//
// A character at stored position n (prefix length m = n+1) goes through setup,
// a suffix walk from length m down to 1 (one length per cycle, against the
// character, answer and suffix-map RAMs, one read port each), drain and commit.
// One past capacity gets an overflow answer. Reset is synchronous and needs no
// clearing pass; the next character is taken while a result waits in the output
// register; a stalled result holds the block only at its next commit or overflow.
module palindromic_length_of_prefixes #(
   parameter int unsigned MAX_LEN = plr_pkg::MAX_LEN_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   plr_req_if.sink   req_chan,
   plr_rsp_if.source rsp_chan
);
   import plr_pkg::*;

   localparam int unsigned MAX_MASKED = MAX_LEN % (2 ** OUT_W);

   plr_cmd_type    cmd;
   plr_status_type status;
   logic           req_ready;

   assign req_chan.ready = req_ready;

   plr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   plr_dp #(.MAX_LEN(MAX_LEN)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_ch            (req_chan.ch),
      .req_starts_string (req_chan.starts_string),
      .cmd               (cmd),
      .status            (status),
      .rsp_chan          (rsp_chan)
   );

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("block took a second character while the first is in progress");

   a_ovf_length: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.overflow |-> rsp_chan.prefix_length == OUT_W'(MAX_MASKED))
      else $error("overflow answer with a prefix length other than capacity");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit || cmd.emit_ovf |-> status.out_free)
      else $error("result register overwritten while holding an answer");

endmodule

FILE: dv/palindromic_length_of_prefixes_tb.sv
// Testbench for the palindromic prefix length block: directed table, random strings, capacity run.
module palindromic_length_of_prefixes_tb;
   import plr_pkg::*;

   localparam int unsigned CAP         = MAX_LEN_DEFAULT;
   localparam int          HALF_PERIOD = 6;
   localparam int          RESET_CYCLES = 9;
   localparam int          CYCLE_LIMIT = 10_000_000;
   localparam int          SHORT_SPLIT = 280;   // short-string characters before the capacity run
   localparam int          SHORT_ITEMS = 540;   // short-string characters in all
   localparam int          OVER_CHARS  = 4;     // characters sent past capacity
   localparam int          TAIL_CYCLES = CAP + 8;

   typedef logic [CHAR_W-1:0] char_type;

   typedef struct packed {
      logic [OUT_W-1:0] prefix_length;
      logic [OUT_W-1:0] min_parts;
      logic             overflow;
   } answer_type;

   typedef struct {
      char_type   ch;
      bit         starts_string;
      bit         typed;
      answer_type answer;
   } stim_row_type;

   typedef enum {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_PERIODIC} ready_mode_type;
   typedef enum {TEXT_BYTES, TEXT_SMALL_ALPHABET, TEXT_PAL_BLOCKS, TEXT_PERIODIC} text_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   plr_req_if req_chan();
   plr_rsp_if rsp_chan();

   palindromic_length_of_prefixes #(.MAX_LEN(CAP)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Mirror of the block state: characters, answers per prefix, palindromic suffix lengths.
   char_type         string_chars [CAP];
   logic [OUT_W-1:0] prefix_parts [CAP];
   bit               pal_suffix   [CAP+1];
   int unsigned      chars_held   = 0;
   bit               capacity_hit = 1'b0;

   answer_type     expected_answers[$];
   int             errors            = 0;
   int             items_sent        = 0;
   int             short_items       = 0;
   int             strings_started   = 0;
   int unsigned    longest_prefix    = 0;
   int             overflow_answers  = 0;
   int             whole_palindromes = 0;
   int unsigned    cycles            = 0;
   int unsigned    burst_left        = 0;
   ready_mode_type ready_mode        = READY_ALWAYS;

   stim_row_type directed_rows[] = '{
      '{8'h61, 1'b0, 1'b1, {11'd1, 11'd1, 1'b0}},
      '{8'h61, 1'b0, 1'b1, {11'd2, 11'd1, 1'b0}},
      '{8'h62, 1'b0, 1'b1, {11'd3, 11'd2, 1'b0}},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, {11'd1, 11'd1, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, {11'd2, 11'd2, 1'b0}},
      '{8'h00, 1'b0, 1'b1, {11'd3, 11'd1, 1'b0}},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h55, 1'b1, 1'b1, {11'd1, 11'd1, 1'b0}},
      '{8'hAA, 1'b0, 1'b1, {11'd2, 11'd2, 1'b0}},
      '{8'h55, 1'b0, 1'b1, {11'd3, 11'd1, 1'b0}},
      '{8'hAA, 1'b0, 1'b0, '0},
      '{8'h61, 1'b1, 1'b1, {11'd1, 11'd1, 1'b0}},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h63, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0}
   };

   // Walk suffix lengths long to short so bit len-2 still describes the previous prefix.
   function automatic answer_type next_answer(input char_type c, input bit fresh);
      answer_type  ans;
      int unsigned m;
      int unsigned best;
      int unsigned cand;
      bit          pal;
      if (fresh) begin
         foreach (pal_suffix[i]) pal_suffix[i] = 1'b0;
         chars_held   = 0;
         capacity_hit = 1'b0;
      end
      if (chars_held >= CAP) begin
         capacity_hit      = 1'b1;
         ans.prefix_length = OUT_W'(CAP);
         ans.min_parts     = prefix_parts[CAP-1];
         ans.overflow      = 1'b1;
         return ans;
      end
      m    = chars_held + 1;
      best = '1;
      for (int len = m; len >= 1; len--) begin
         if (len == 1)
            pal = 1'b1;
         else if (len == 2)
            pal = (string_chars[chars_held-1] == c);
         else
            pal = (string_chars[m-len] == c) && pal_suffix[len-2];
         pal_suffix[len] = pal;
         if (pal) begin
            cand = (m == len) ? 0 : prefix_parts[m-len-1];
            if (cand < best) best = cand;
         end
      end
      string_chars[chars_held] = c;
      prefix_parts[chars_held] = OUT_W'(best + 1);
      chars_held               = m;
      ans.prefix_length        = OUT_W'(m);
      ans.min_parts            = OUT_W'(best + 1);
      ans.overflow             = capacity_hit;
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0d, want %0d", $time, what, got, want);
      errors++;
   endtask

   // Receiver: stall pattern redrawn at random among always-ready, coin-flip, sparse and periodic modes.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles % 97 == 0) ready_mode <= ready_mode_type'($urandom_range(0, 3));
      case (ready_mode)
         READY_ALWAYS: rsp_chan.ready <= 1'b1;
         READY_COIN:   rsp_chan.ready <= ($urandom_range(0, 1) == 0);
         READY_SPARSE: rsp_chan.ready <= ($urandom_range(0, 9) == 0);
         default:      rsp_chan.ready <= (cycles % 5 != 3);
      endcase
   end

   always @(posedge clock) begin : check_results
      answer_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (rsp_chan.overflow === 1'b1) overflow_answers++;
         if (rsp_chan.min_parts == 1 && rsp_chan.prefix_length > 1 && rsp_chan.overflow === 1'b0)
            whole_palindromes++;
         if (expected_answers.size() == 0) begin
            report_mismatch("unexpected transfer, prefix_length",
                            32'(rsp_chan.prefix_length), 32'(0));
         end else begin
            want = expected_answers.pop_front();
            if (rsp_chan.prefix_length !== want.prefix_length)
               report_mismatch("prefix_length", 32'(rsp_chan.prefix_length),
                               32'(want.prefix_length));
            if (rsp_chan.min_parts !== want.min_parts)
               report_mismatch("min_parts", 32'(rsp_chan.min_parts), 32'(want.min_parts));
            if (rsp_chan.overflow !== want.overflow)
               report_mismatch("overflow", 32'(rsp_chan.overflow), 32'(want.overflow));
         end
      end
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d results outstanding", cycles,
               expected_answers.size());
      $display("DONE: errors detected");
      $finish;
   end

   // Sender: bursts of random length, gaps of random length.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 6);
      end
   endtask

   task automatic send_char(input char_type c, input bit fresh, input bit typed,
                            input answer_type typed_answer);
      answer_type predicted;
      pace_sender();
      req_chan.valid         <= 1'b1;
      req_chan.ch            <= c;
      req_chan.starts_string <= fresh;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      predicted = next_answer(c, fresh);
      expected_answers.push_back(typed ? typed_answer : predicted);
      items_sent++;
      if (fresh) strings_started++;
      if (chars_held > longest_prefix) longest_prefix = chars_held;
   endtask

   // Hold the sender off until every transfer has been answered.
   task automatic wait_for_results();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_answers.size() != 0);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 24);
      if (r < 95) return $urandom_range(25, 80);
      return $urandom_range(81, 200);
   endfunction

   function automatic void fill_text(ref char_type text[$], input int len);
      text_mode_type mode;
      char_type      base;
      char_type      half[$];
      char_type      word[$];
      int            alpha;
      int            piece;
      int            period;
      text.delete();
      mode   = text_mode_type'($urandom_range(0, 3));
      base   = char_type'($urandom_range(0, 255));
      alpha  = $urandom_range(1, 3);
      period = $urandom_range(1, 5);
      case (mode)
         TEXT_BYTES: begin
            while (text.size() < len) text.push_back(char_type'($urandom_range(0, 255)));
         end
         TEXT_SMALL_ALPHABET: begin
            while (text.size() < len)
               text.push_back(char_type'(base + $urandom_range(0, alpha - 1)));
         end
         TEXT_PAL_BLOCKS: begin
            while (text.size() < len) begin
               piece = $urandom_range(1, 12);
               half.delete();
               for (int i = 0; i < (piece + 1) / 2; i++)
                  half.push_back(char_type'(base + $urandom_range(0, alpha)));
               foreach (half[i]) text.push_back(half[i]);
               for (int i = piece / 2 - 1; i >= 0; i--) text.push_back(half[i]);
            end
         end
         default: begin
            for (int i = 0; i < period; i++)
               word.push_back(char_type'(base + $urandom_range(0, alpha)));
            // mostly a repeated word, with a stray byte now and then
            while (text.size() < len)
               text.push_back(($urandom_range(0, 19) == 0) ? char_type'($urandom_range(0, 255))
                                                          : word[text.size() % period]);
         end
      endcase
      while (text.size() > len) void'(text.pop_back());
   endfunction

   task automatic send_text(ref char_type text[$], input bit fresh);
      foreach (text[i]) send_char(text[i], fresh && i == 0, 1'b0, '0);
   endtask

   task automatic send_short_strings(input int upto);
      char_type text[$];
      int       len;
      bit       fresh;
      while (short_items < upto) begin
         len   = pick_length();
         // append to the current string now and then instead of starting a new one
         fresh = !($urandom_range(0, 6) == 0 && !capacity_hit && chars_held + len <= 300);
         fill_text(text, len);
         send_text(text, fresh);
         short_items += len;
         if ($urandom_range(0, 39) == 0) wait_for_results();
      end
   endtask

   initial begin
      char_type text[$];
      int       run_sent;
      int       len;
      req_chan.valid         = 1'b0;
      req_chan.ch            = '0;
      req_chan.starts_string = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_char(directed_rows[i].ch, directed_rows[i].starts_string, directed_rows[i].typed,
                   directed_rows[i].answer);
      wait_for_results();

      send_short_strings(SHORT_SPLIT);
      wait_for_results();

      // Fill the stores to capacity, then push a few characters past it.
      run_sent = 0;
      while (run_sent < CAP + OVER_CHARS) begin
         len = pick_length();
         if (len > CAP + OVER_CHARS - run_sent) len = CAP + OVER_CHARS - run_sent;
         fill_text(text, len);
         send_text(text, run_sent == 0);
         run_sent += len;
      end
      wait_for_results();

      send_short_strings(SHORT_ITEMS);

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (expected_answers.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d characters in %0d started strings; longest stored prefix %0d.",
               items_sent, strings_started, longest_prefix);
      $display("Answers past capacity: %0d; prefixes that were one whole palindrome: %0d.",
               overflow_answers, whole_palindromes);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/plr_pkg.sv
hw/rtl/plr_channels.sv
hw/rtl/plr_ram.sv
hw/rtl/plr_ctrl.sv
hw/rtl/plr_dp.sv
hw/rtl/palindromic_length_of_prefixes.sv
dv/palindromic_length_of_prefixes_tb.sv
